/* rtl/core/tkvs_pkg.sv */
// ----------------------------------------------------------------------------
// tkvs_pkg: shared types and constants for top-k by volume selection
// field structs, sequencer states and sizing constants
// ----------------------------------------------------------------------------
package tkvs_pkg;

   localparam int MAX_SELECT = 64;
   localparam int ID_BITS    = 16;
   localparam int DIM_BITS   = 12;
   localparam int VOL_BITS   = 3 * DIM_BITS;
   localparam int IDX_BITS   = $clog2(MAX_SELECT);
   localparam int CNT_BITS   = IDX_BITS + 1;
   localparam int SEL_BITS   = 7;

   typedef struct packed {
      logic [15:0] item_id;
      logic [11:0] height;
      logic [11:0] width;
      logic [11:0] length;
      logic        last_item;
   } req_type;

   typedef struct packed {
      logic [15:0] chosen_id;
      logic        final_result;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_SCAN,
      ST_SHIFT,
      ST_PUT,
      ST_SORT_RD,
      ST_SORT_CMP,
      ST_EMIT_RD,
      ST_EMIT
   } state_type;

endpackage

/* rtl/core/tkvs_mul.sv */
// ----------------------------------------------------------------------------
// tkvs_mul: shared multiplier
// one registered product per cycle while load is high, used twice per item for the volume
// ----------------------------------------------------------------------------
module tkvs_mul
   import tkvs_pkg::*;
(
   input  logic                  clock,
   input  logic                  load,
   input  logic [2*DIM_BITS-1:0] op_a,
   input  logic [DIM_BITS-1:0]   op_b,
   output logic [VOL_BITS-1:0]   product
);

   logic [VOL_BITS-1:0] product_ff, product_in;

   assign product_in = VOL_BITS'(op_a) * VOL_BITS'(op_b);

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

/* rtl/core/top_k_by_volume_select.sv */
// ----------------------------------------------------------------------------
// top_k_by_volume_select: keeps the k largest-volume items, reports their ids
// sorted by id when the last item of a set arrives
// ----------------------------------------------------------------------------
// flow: volume multiply in ST_MUL1 and ST_MUL2, then the scan reads one kept
// entry a cycle and the shift moves one entry a cycle to insert the item
// a last item then copies the n kept ids into scratch and selection-sorts
// them: each slot p is filled by a compare pass over p..n-1 and one emit
// throughput: one item at a time, busy stays high for the whole item
// reset (synchronous) clears the kept count, select_count to 1; no rsp stall
module top_k_by_volume_select
   import tkvs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_data,
   output logic                rsp_valid,
   output rsp_type             rsp_data,
   input  logic                csr_write,
   input  logic [SEL_BITS-1:0] csr_data
);

   // kept list, best first
   logic [VOL_BITS-1:0] vol_mem [MAX_SELECT];
   logic [ID_BITS-1:0]  id_mem  [MAX_SELECT];
   // scratch copy of ids for the output sort (undefined until written)
   logic [ID_BITS-1:0]  srt_mem [MAX_SELECT];

   state_type state_ff, state_in;
   logic [SEL_BITS-1:0] sel_ff;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [CNT_BITS-1:0] k_eff;
   logic [CNT_BITS-1:0] p_ff, p_in;       // scan / shift / sort pointer
   logic [CNT_BITS-1:0] j_ff, j_in;       // sort inner pointer
   logic [CNT_BITS-1:0] n_ff, n_in;       // entries used this insert / emit
   req_type             req_ff;
   logic [ID_BITS-1:0]  rd_id_ff;
   logic [VOL_BITS-1:0] rd_vol_ff;
   logic [ID_BITS-1:0]  min_ff, min_in;
   logic [CNT_BITS-1:0] mpos_ff, mpos_in;
   logic                mul_load;
   logic [2*DIM_BITS-1:0] mul_a;
   logic [DIM_BITS-1:0] mul_b;
   logic [VOL_BITS-1:0] product;

   // memory control
   logic                kmem_we, smem_we;
   logic [IDX_BITS-1:0] kmem_wa, kmem_ra, smem_wa, smem_ra;
   logic [VOL_BITS-1:0] kmem_wv;
   logic [ID_BITS-1:0]  kmem_wi, smem_wd;
   logic [ID_BITS-1:0]  srd_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_in;
   logic                ahead;

   // product holds the volume from the end of ST_MUL2 until the next item
   tkvs_mul u_mul (
      .clock   (clock),
      .load    (mul_load),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   // effective k clamped to 1..MAX_SELECT
   always_comb begin
      if (sel_ff == '0) begin
         k_eff = CNT_BITS'(1);
      end else if (32'(sel_ff) > MAX_SELECT) begin
         k_eff = CNT_BITS'(MAX_SELECT);
      end else begin
         k_eff = CNT_BITS'(sel_ff);
      end
   end

   assign ahead = (product > rd_vol_ff) ||
                  (product == rd_vol_ff && req_ff.item_id < rd_id_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         sel_ff    <= SEL_BITS'(1);
         cnt_ff    <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rsp_valid <= rsp_valid_in;
         if (csr_write) begin
            sel_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      j_ff    <= j_in;
      n_ff    <= n_in;
      min_ff  <= min_in;
      mpos_ff <= mpos_in;
      rsp_data <= rsp_in;
      if (start && !busy) begin
         req_ff <= req_data;
      end
      if (kmem_we) begin
         vol_mem[kmem_wa] <= kmem_wv;
         id_mem[kmem_wa]  <= kmem_wi;
      end
      rd_vol_ff <= vol_mem[kmem_ra];
      rd_id_ff  <= id_mem[kmem_ra];
      if (smem_we) begin
         srt_mem[smem_wa] <= smem_wd;
      end
      srd_ff <= srt_mem[smem_ra];
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      p_in         = p_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      min_in       = min_ff;
      mpos_in      = mpos_ff;
      mul_load     = 1'b0;
      mul_a        = (2*DIM_BITS)'(req_ff.height);
      mul_b        = req_ff.width;
      kmem_we      = 1'b0;
      kmem_wa      = p_ff[IDX_BITS-1:0];
      kmem_ra      = p_ff[IDX_BITS-1:0];
      kmem_wv      = product;
      kmem_wi      = req_ff.item_id;
      smem_we      = 1'b0;
      smem_wa      = p_ff[IDX_BITS-1:0];
      smem_wd      = rd_id_ff;
      smem_ra      = j_ff[IDX_BITS-1:0];
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_data;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            // height * width
            mul_load = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            // (height * width) * length
            mul_load = 1'b1;
            mul_a    = product[2*DIM_BITS-1:0];
            mul_b    = req_ff.length;
            n_in     = (cnt_ff > k_eff) ? k_eff : cnt_ff;
            p_in     = '0;
            kmem_ra  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // rd_* hold entry p
            if (p_ff >= n_ff || ahead) begin
               if (p_ff >= k_eff) begin
                  // dropped: kept count stays as it was
                  if (req_ff.last_item) begin
                     p_in = '0; state_in = ST_SORT_RD;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  n_in    = (n_ff < k_eff) ? n_ff + 1'b1 : k_eff;
                  mpos_in = p_ff;                      // insertion point
                  j_in    = ((n_ff < k_eff) ? n_ff + 1'b1 : k_eff) - 1'b1;
                  kmem_ra = j_in[IDX_BITS-1:0] - 1'b1;
                  state_in = ST_SHIFT;
               end
            end else begin
               p_in    = p_ff + 1'b1;
               kmem_ra = p_in[IDX_BITS-1:0];
            end
         end
         ST_SHIFT: begin
            // rd_* hold entry j-1
            if (j_ff > mpos_ff) begin
               kmem_we = 1'b1;
               kmem_wa = j_ff[IDX_BITS-1:0];
               kmem_wv = rd_vol_ff;
               kmem_wi = rd_id_ff;
               j_in    = j_ff - 1'b1;
               kmem_ra = j_in[IDX_BITS-1:0] - 1'b1;
               state_in = ST_SHIFT;
               if (j_in == mpos_ff) begin
                  state_in = ST_PUT;
               end
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            kmem_we = 1'b1;
            kmem_wa = mpos_ff[IDX_BITS-1:0];
            cnt_in  = n_ff;
            if (req_ff.last_item) begin
               p_in     = '0;
               kmem_ra  = '0;
               state_in = ST_SORT_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SORT_RD: begin
            // copy the n kept ids into scratch, one a cycle (read lags by one)
            if (p_ff != '0) begin
               smem_we = 1'b1;
               smem_wa = p_ff[IDX_BITS-1:0] - 1'b1;
            end
            if (p_ff == n_ff) begin
               p_in     = '0;
               j_in     = '0;
               smem_ra  = '0;
               state_in = ST_EMIT_RD;
            end else begin
               p_in    = p_ff + 1'b1;
            end
         end
         ST_EMIT_RD: begin
            // p is the output slot; j scans p..n-1 for the minimum
            if (j_ff == p_ff) begin
               min_in  = '1;
               mpos_in = p_ff;
            end
            smem_ra  = j_ff[IDX_BITS-1:0];
            state_in = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            // srd_ff holds entry j; strict less keeps the first minimum
            if (srd_ff < min_ff || j_ff == p_ff) begin
               min_in  = srd_ff;
               mpos_in = j_ff;
            end
            if (j_ff + 1'b1 >= n_ff) begin
               smem_ra  = p_ff[IDX_BITS-1:0];
               state_in = ST_EMIT;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT: begin
            // srd_ff holds slot p; swap it into the minimum's place
            rsp_valid_in        = 1'b1;
            rsp_in.chosen_id    = 16'(min_ff);
            rsp_in.final_result = (p_ff + 1'b1 == n_ff);
            smem_we = 1'b1;
            smem_wa = mpos_ff[IDX_BITS-1:0];
            smem_wd = srd_ff;
            if (p_ff + 1'b1 == n_ff) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               p_in     = p_ff + 1'b1;
               j_in     = p_ff + 1'b1;
               state_in = ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for top_k_by_volume_select
// drives item sets through the command port, predicts the selected ids in
// software and checks every response transaction against the expected queue
// ----------------------------------------------------------------------------
module tb;
   import tkvs_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   req_type             req_data = '0;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_write = 1'b0;
   logic [SEL_BITS-1:0] csr_data = '0;

   // predictor state: running best list, best first
   logic [VOL_BITS-1:0] best_vol [MAX_SELECT];
   logic [ID_BITS-1:0]  best_id  [MAX_SELECT];
   int                  best_cnt;
   logic [SEL_BITS-1:0] sel_reg;

   rsp_type expected_ids[$];
   int      error_count = 0;
   int      cycle_count = 0;
   bit      idle_on = 1'b1;

   localparam int CYCLE_LIMIT = 2000000;

   always #5 clock = ~clock;

   top_k_by_volume_select dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_data  (csr_data)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch @%0t: %s", $realtime, what);
      error_count++;
   endtask

   // checker: one response transaction per rsp_valid cycle
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_ids.size() == 0) begin
            report_mismatch($sformatf("unexpected id %0h", rsp_data.chosen_id));
         end else begin
            want = expected_ids.pop_front();
            if (rsp_data.chosen_id !== want.chosen_id)
               report_mismatch($sformatf("chosen_id %0h want %0h",
                                         rsp_data.chosen_id, want.chosen_id));
            if (rsp_data.final_result !== want.final_result)
               report_mismatch($sformatf("final_result %0b want %0b id %0h",
                                         rsp_data.final_result,
                                         want.final_result, want.chosen_id));
         end
      end
   end

   function automatic int select_k();
      int k;
      k = sel_reg;
      if (k < 1) k = 1;
      if (k > MAX_SELECT) k = MAX_SELECT;
      return k;
   endfunction

   // update the best list with one item; on a last item queue the sorted ids
   task automatic predict_selection(input req_type it);
      logic [VOL_BITS-1:0] vol;
      logic [ID_BITS-1:0]  ids [$];
      rsp_type             r;
      int k, cnt, p, n;
      vol = VOL_BITS'(it.height) * VOL_BITS'(it.width) * VOL_BITS'(it.length);
      k = select_k();
      cnt = (best_cnt > k) ? k : best_cnt;
      p = 0;
      while (p < cnt && !((vol > best_vol[p]) ||
                          (vol == best_vol[p] && it.item_id < best_id[p])))
         p++;
      if (p < k) begin
         n = (cnt < k) ? cnt + 1 : k;
         for (int j = n - 1; j > p; j--) begin
            best_vol[j] = best_vol[j-1];
            best_id[j]  = best_id[j-1];
         end
         best_vol[p] = vol;
         best_id[p]  = it.item_id;
         best_cnt = n;
      end
      if (it.last_item) begin
         n = (best_cnt > k) ? k : best_cnt;
         for (int i = 0; i < n; i++) ids.push_back(best_id[i]);
         ids.sort();
         for (int i = 0; i < n; i++) begin
            r.chosen_id    = ids[i];
            r.final_result = (i == n - 1);
            expected_ids.push_back(r);
         end
         best_cnt = 0;
      end
   endtask

   task automatic idle_burst();
      if (idle_on && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 13)) @(posedge clock);
   endtask

   // one command transaction: hold start until accepted
   task automatic send_item(input req_type it);
      idle_burst();
      start    <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (busy);
      predict_selection(it);
      start <= 1'b0;
      // dut is busy after the accepting edge
      @(posedge clock);
   endtask

   // only between sets, with everything drained
   task automatic write_select(input int value);
      wait_drained();
      csr_write <= 1'b1;
      csr_data  <= SEL_BITS'(value);
      @(posedge clock);
      csr_write <= 1'b0;
      sel_reg = SEL_BITS'(value);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (expected_ids.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic req_type make_item(input bit last);
      req_type it;
      it.item_id   = 16'($urandom);
      it.height    = 12'($urandom);
      it.width     = 12'($urandom);
      it.length    = 12'($urandom);
      it.last_item = last;
      // some small dims and small ids to get volume and id ties
      if ($urandom_range(0, 3) == 0) begin
         it.height = 12'($urandom_range(0, 3));
         it.width  = 12'($urandom_range(0, 3));
         it.length = 12'($urandom_range(0, 3));
         it.item_id = 16'($urandom_range(0, 7));
      end
      return it;
   endfunction

   function automatic req_type fixed_item(input int id, input int h, input int w,
                                          input int l, input bit last);
      req_type it;
      it.item_id = 16'(id); it.height = 12'(h); it.width = 12'(w);
      it.length = 12'(l); it.last_item = last;
      return it;
   endfunction

   // extremes of the fields, reset k of one, lone last item
   task automatic test_extremes();
      send_item(fixed_item(16'hFFFF, 4095, 4095, 4095, 1'b1));
      send_item(fixed_item(0, 0, 0, 0, 1'b1));
      send_item(fixed_item(16'h5555, 4095, 4095, 4095, 1'b0));
      send_item(fixed_item(16'hAAAA, 12'h555, 12'hAAA, 12'h555, 1'b1));
   endtask

   // zero k, saturated k, fewer items than k, volume ties and equal ids
   task automatic test_select_limits();
      write_select(0);
      send_item(fixed_item(7, 2, 2, 2, 1'b0));
      send_item(fixed_item(3, 2, 2, 2, 1'b1));
      write_select(127);
      send_item(fixed_item(9, 1, 2, 3, 1'b0));
      send_item(fixed_item(9, 3, 2, 1, 1'b0));
      send_item(fixed_item(2, 6, 1, 1, 1'b0));
      send_item(fixed_item(16'hFFFF, 0, 9, 9, 1'b1));
      write_select(3);
      send_item(fixed_item(5, 4, 4, 4, 1'b0));
      send_item(fixed_item(5, 4, 4, 4, 1'b0));
      send_item(fixed_item(1, 1, 1, 1, 1'b0));
      send_item(fixed_item(4, 8, 8, 8, 1'b0));
      send_item(fixed_item(8, 4, 4, 4, 1'b1));
   endtask

   // k changed within a set: lowered then raised again
   task automatic test_k_change_in_set();
      write_select(4);
      for (int i = 0; i < 4; i++) send_item(make_item(1'b0));
      wait_drained();
      csr_write <= 1'b1; csr_data <= 7'd2; @(posedge clock);
      csr_write <= 1'b0; sel_reg = 7'd2;
      send_item(make_item(1'b0));
      wait_drained();
      csr_write <= 1'b1; csr_data <= 7'd5; @(posedge clock);
      csr_write <= 1'b0; sel_reg = 7'd5;
      send_item(make_item(1'b0));
      send_item(make_item(1'b1));
   endtask

   // random sets, mostly small k with a few at the maximum
   task automatic test_random_sets();
      int sent, len, k;
      sent = 0;
      while (sent < 180) begin
         case ($urandom_range(0, 9))
            0:       k = 64;
            1:       k = $urandom_range(65, 127);
            2:       k = 0;
            default: k = $urandom_range(1, 8);
         endcase
         write_select(k);
         len = (k >= 64) ? $urandom_range(40, 80) : $urandom_range(1, 12);
         if (len > 180 - sent) len = 180 - sent;
         if (sent > 150) idle_on = 1'b0;
         for (int i = 0; i < len; i++) begin
            send_item(make_item(i == len - 1));
            sent++;
         end
      end
   endtask

   initial begin
      sel_reg  = 7'd1;
      best_cnt = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_select_limits();
      test_k_change_in_set();
      test_random_sets();
      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
